// ----- rtl/positional_list_engine_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the positional list engine core
// Concurrent checks on clk, disabled while rst_n is low; empty when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// consequent must hold in the same cycle as the antecedent
`define PLE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// consequent must hold in the cycle after the antecedent
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define PLE_ASSERT_NOW(lbl, ante, cons)
`define PLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/ple_pkg.sv -----
// ---------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and widths of the positional list engine.
// ---------------------------------------------------------------------------
package ple_pkg;

  // default sizing of the store
  localparam int CAPACITY_DEF      = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // fixed port field widths
  localparam int ACTION_W = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_GET     = 3'd2,
    ACT_SEARCH  = 3'd3,
    ACT_APPEND  = 3'd4,
    ACT_PREPEND = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP,
    S_DOWN,
    S_SEARCH,
    S_GET,
    S_REPLY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    init_up;
    logic    init_down;
    logic    init_search;
    logic    step_up;
    logic    step_down;
    logic    step_search;
    logic    take_get;
    logic    set_status;
    status_t status_code;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                pos_gt_cnt;
    logic                pos_ge_cnt;
    logic                full;
    logic                up_done;
    logic                scan_end;
    logic                search_hit;
  } dp_sts_t;

endpackage

// ----- rtl/ple_ram.sv -----
// ---------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ple_ctrl.sv -----
// ---------------------------------------------------------------------------
// ple_ctrl
// Controller: decodes each request and sequences the datapath walks.
// ---------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd,
  output logic      busy,
  output logic      out_strobe
);

  state_t state_r;
  state_t state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_REPLY;
        case (sts.act)
          ACT_INSERT: begin
            if (sts.pos_gt_cnt) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end else if (sts.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.init_up = 1'b1;
              state_nxt   = S_UP;
            end
          end
          ACT_REMOVE: begin
            if (sts.pos_ge_cnt) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end else begin
              cmd.init_down = 1'b1;
              state_nxt     = S_DOWN;
            end
          end
          ACT_GET: begin
            if (sts.pos_ge_cnt) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end else begin
              state_nxt = S_GET;
            end
          end
          ACT_SEARCH: begin
            cmd.init_search = 1'b1;
            state_nxt       = S_SEARCH;
          end
          ACT_APPEND, ACT_PREPEND: begin
            if (sts.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.init_up = 1'b1;
              state_nxt   = S_UP;
            end
          end
          default: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_RANGE;
          end
        endcase
      end
      S_UP: begin
        cmd.step_up = 1'b1;
        if (sts.up_done) begin
          state_nxt = S_REPLY;
        end
      end
      S_DOWN: begin
        cmd.step_down = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_REPLY;
        end
      end
      S_SEARCH: begin
        cmd.step_search = 1'b1;
        if (sts.search_hit) begin
          state_nxt = S_REPLY;
        end else if (sts.scan_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_MISS;
          state_nxt       = S_REPLY;
        end
      end
      S_GET: begin
        cmd.take_get = 1'b1;
        state_nxt    = S_REPLY;
      end
      S_REPLY: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_REPLY);

endmodule

// ----- rtl/ple_datapath.sv -----
// ---------------------------------------------------------------------------
// ple_datapath
// Element store, count, walk pointer and result registers of the engine.
// ---------------------------------------------------------------------------
`include "positional_list_engine_core_assert.svh"

module ple_datapath import ple_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_sts_t             sts,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [POS_W-1:0]    in_position,
  input  logic [VALUE_W-1:0]  in_value,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_data_out,
  output logic [INDEX_W-1:0]  out_found_index,
  output logic [COUNT_W-1:0]  out_item_count
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // request registers
  logic [ACTION_W-1:0]      act_r, act_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [ELEMENT_WIDTH-1:0] val_r, val_nxt;

  // list and walk state
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] gap_r, gap_nxt;
  logic [CW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_pend_r, rd_pend_nxt;

  // result registers
  status_t            status_r, status_nxt;
  logic [DATA_W-1:0]  data_r, data_nxt;
  logic [INDEX_W-1:0] found_r, found_nxt;

  // store port
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic [ELEMENT_WIDTH-1:0] rdata;

  logic [CW-1:0]   ptr_dec;
  logic [CW-1:0]   ptr_inc;
  logic [CW-1:0]   addr_inc;
  logic [CW-1:0]   addr_dec;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;

  ple_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ptr_dec  = ptr_r - 1'b1;
  assign ptr_inc  = ptr_r + 1'b1;
  assign addr_inc = rd_addr_r + 1'b1;
  assign addr_dec = rd_addr_r - 1'b1;
  assign pos_ext  = CMPW'(pos_r);
  assign cnt_ext  = CMPW'(count_r);

  // status towards the controller
  always_comb begin
    sts.act        = act_r;
    sts.pos_gt_cnt = (pos_ext > cnt_ext);
    sts.pos_ge_cnt = (pos_ext >= cnt_ext);
    sts.full       = (count_r == CW'(CAPACITY));
    sts.up_done    = (ptr_r == gap_r) && !rd_pend_r;
    sts.scan_end   = (ptr_r == count_r) && !rd_pend_r;
    sts.search_hit = rd_pend_r && (rdata == val_r);
  end

  // next-state logic of the walks
  always_comb begin
    act_nxt     = act_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    gap_nxt     = gap_r;
    rd_addr_nxt = rd_addr_r;
    rd_pend_nxt = 1'b0;
    status_nxt  = status_r;
    data_nxt    = data_r;
    found_nxt   = found_r;
    we          = 1'b0;
    waddr       = '0;
    wdata       = rdata;
    // read ahead at the requested position while decoding
    raddr       = AW'(pos_r);

    // capture a new request beat
    if (cmd.load) begin
      act_nxt    = in_action;
      pos_nxt    = in_position;
      val_nxt    = ELEMENT_WIDTH'(in_value);
      status_nxt = ST_OK;
      data_nxt   = '0;
      found_nxt  = '0;
    end

    if (cmd.set_status) begin
      status_nxt = cmd.status_code;
    end

    // open a gap: walk down from the top
    if (cmd.init_up) begin
      ptr_nxt = count_r;
      if (act_r == ACT_INSERT) begin
        gap_nxt = CW'(pos_r);
      end else if (act_r == ACT_APPEND) begin
        gap_nxt = count_r;
      end else begin
        gap_nxt = '0;
      end
    end

    if (cmd.init_down) begin
      gap_nxt = CW'(pos_r);
      ptr_nxt = CW'(pos_r);
    end

    if (cmd.init_search) begin
      ptr_nxt = '0;
    end

    // shift up: read k-1, write the returned read data to k, then drop in the value
    if (cmd.step_up) begin
      if (ptr_r > gap_r) begin
        raddr       = ptr_dec[AW-1:0];
        rd_pend_nxt = 1'b1;
        rd_addr_nxt = ptr_dec;
        ptr_nxt     = ptr_dec;
      end
      if (rd_pend_r) begin
        we    = 1'b1;
        waddr = addr_inc[AW-1:0];
        wdata = rdata;
      end else if (ptr_r == gap_r) begin
        we        = 1'b1;
        waddr     = gap_r[AW-1:0];
        wdata     = val_r;
        count_nxt = count_r + 1'b1;
      end
    end

    // shift down: first read is the removed element, the rest move down one
    if (cmd.step_down) begin
      if (ptr_r < count_r) begin
        raddr       = ptr_r[AW-1:0];
        rd_pend_nxt = 1'b1;
        rd_addr_nxt = ptr_r;
        ptr_nxt     = ptr_inc;
      end
      if (rd_pend_r) begin
        if (rd_addr_r == gap_r) begin
          data_nxt = DATA_W'(rdata);
        end else begin
          we    = 1'b1;
          waddr = addr_dec[AW-1:0];
          wdata = rdata;
        end
      end
      if (sts.scan_end) begin
        count_nxt = count_r - 1'b1;
      end
    end

    // search: read one element a cycle, compare it when its read data returns
    if (cmd.step_search) begin
      if (ptr_r < count_r) begin
        raddr       = ptr_r[AW-1:0];
        rd_pend_nxt = 1'b1;
        rd_addr_nxt = ptr_r;
        ptr_nxt     = ptr_inc;
      end
      if (sts.search_hit) begin
        found_nxt = INDEX_W'(rd_addr_r);
      end
    end

    if (cmd.take_get) begin
      data_nxt = DATA_W'(rdata);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    ptr_r     <= ptr_nxt;
    gap_r     <= gap_nxt;
    rd_addr_r <= rd_addr_nxt;
    status_r  <= status_nxt;
    data_r    <= data_nxt;
    found_r   <= found_nxt;
  end

  assign out_status      = status_r;
  assign out_data_out    = data_r;
  assign out_found_index = found_r;
  assign out_item_count  = COUNT_W'(count_r);

  // a finished shift-up adds exactly one element
  `PLE_ASSERT_NEXT(a_up_adds_one, cmd.step_up && sts.up_done,
    count_r == $past(count_r) + 1'b1)
  // a finished shift-down removes exactly one element
  `PLE_ASSERT_NEXT(a_down_drops_one, cmd.step_down && sts.scan_end,
    count_r == $past(count_r) - 1'b1)
  // never open a gap in a full list
  `PLE_ASSERT_NOW(a_no_up_when_full, cmd.step_up, count_r != CW'(CAPACITY))

endmodule

// ----- rtl/positional_list_engine_core.sv -----
// ---------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list in a fixed store with insert, remove, get, search, append
// and prepend; one result beat per request.
// ---------------------------------------------------------------------------
//  channel   handshake          payload
//  input     start & !busy      in_action, in_position, in_value
//  result    out_strobe         out_status, out_data_out, out_found_index,
//                               out_item_count
//
//  A request takes its accept cycle, S_DECODE, its walk, then S_REPLY.
//  Insert/append/prepend walk S_UP over the elements from the gap up,
//  remove walks S_DOWN from the position up, search walks S_SEARCH to
//  the hit or the end; get passes through S_GET and refused requests go
//  straight from S_DECODE to S_REPLY. The walk reads one stored element
//  per cycle through the single-read-port store and drains the last read;
//  the longest walks are a remove at the head of a full list, or a miss in a full list.
//  Reset (rst_n low, synchronous) empties the list; no clearing pass.
//  busy stays high from acceptance to the reply beat; the reply beat holds
//  for exactly one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
module positional_list_engine_core import ple_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [POS_W-1:0]    in_position,
  input  logic [VALUE_W-1:0]  in_value,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_data_out,
  output logic [INDEX_W-1:0]  out_found_index,
  output logic [COUNT_W-1:0]  out_item_count
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  ple_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  ple_datapath #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_found_index (out_found_index),
    .out_item_count  (out_item_count)
  );

endmodule
